[rtl/core/divisor_count_trial_division_defines.svh]
// assertion macros for the rtl, used by dct_factor
`ifndef DIVISOR_COUNT_TRIAL_DIVISION_DEFINES_SVH
`define DIVISOR_COUNT_TRIAL_DIVISION_DEFINES_SVH

// same-cycle implication
`define DCT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DCT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/dct_pkg.sv]
package dct_pkg;

    localparam int PRIME_LIMIT = 65536;
    localparam int NUMBER_BITS = 32;
    localparam int PRIME_SLOTS = 8192;

    // mark store address and prime width
    localparam int MARK_AW  = $clog2(PRIME_LIMIT);
    localparam int SCAN_W   = MARK_AW + 1;
    localparam int ROOT_W   = MARK_AW / 2 + 1;
    localparam int SLOT_AW  = $clog2(PRIME_SLOTS);
    localparam int TOTAL_W  = SLOT_AW + 1;
    localparam int COUNT_W  = 11;
    localparam int EXP_W    = $clog2(NUMBER_BITS + 2);
    localparam int DIV_CW   = $clog2(NUMBER_BITS + 1);

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // prime list write from the sieve
    typedef struct packed {
        logic               we;
        logic [SLOT_AW-1:0] addr;
        logic [MARK_AW-1:0] data;
    } plist_wr_t;

endpackage

[rtl/core/dct_plist.sv]
module dct_plist
    import dct_pkg::*;
(
    input  logic               clk,
    input  plist_wr_t          wr,
    input  logic [SLOT_AW-1:0] rd_addr,
    output logic [MARK_AW-1:0] rd_data
);

    logic [MARK_AW-1:0] mem [PRIME_SLOTS];

    // one write port, registered read
    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

[rtl/core/dct_sieve.sv]
module dct_sieve
    import dct_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    output plist_wr_t          pwr,
    output logic               done,
    output logic [TOTAL_W-1:0] total
);

    typedef enum logic [2:0] {
        S_CLEAR, S_SCAN_RD, S_SCAN_CHK, S_MARK, S_LIST, S_DONE
    } state_t;

    localparam logic [SCAN_W-1:0] LIMIT_V = SCAN_W'(PRIME_LIMIT);
    localparam logic [SCAN_W-1:0] LAST_V  = SCAN_W'(PRIME_LIMIT - 1);

    state_t             state_reg;
    logic [SCAN_W-1:0]  addr_reg;
    logic [ROOT_W-1:0]  root_reg;
    logic [SCAN_W-1:0]  step_reg;
    logic               lv_reg;
    logic [SCAN_W-1:0]  la_reg;
    logic [TOTAL_W-1:0] total_reg;

    logic               mark [PRIME_LIMIT];
    logic               mem_we;
    logic               mem_wd;
    logic [MARK_AW-1:0] mem_wa;
    logic [MARK_AW-1:0] mem_ra;
    logic               mem_rd;

    logic [2*ROOT_W-1:0] sq;
    logic [SCAN_W-1:0]   step_next;

    assign sq        = root_reg * root_reg;
    assign step_next = addr_reg + SCAN_W'(root_reg);

    // mark store port selection
    always_comb
    begin
        mem_we = 1'b0;
        mem_wd = 1'b0;
        mem_wa = addr_reg[MARK_AW-1:0];
        mem_ra = addr_reg[MARK_AW-1:0];
        case (state_reg)
            S_CLEAR:
            begin
                mem_we = 1'b1;
            end
            S_SCAN_RD:
            begin
                mem_ra = MARK_AW'(root_reg);
            end
            S_MARK:
            begin
                mem_we = 1'b1;
                mem_wd = 1'b1;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // mark store
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mark[mem_wa] <= mem_wd;
        end
        mem_rd <= mark[mem_ra];
    end

    // sieve sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            addr_reg  <= '0;
            root_reg  <= '0;
            step_reg  <= '0;
            lv_reg    <= 1'b0;
            la_reg    <= '0;
            total_reg <= '0;
        end
        else
        begin
            lv_reg <= 1'b0;
            // list pipeline: mem_rd holds the registered mark of la_reg while lv_reg is high
            if (lv_reg && !mem_rd && total_reg < TOTAL_W'(PRIME_SLOTS))
            begin
                total_reg <= total_reg + 1'b1;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    addr_reg <= addr_reg + 1'b1;
                    if (addr_reg == LAST_V)
                    begin
                        root_reg  <= ROOT_W'(2);
                        state_reg <= S_SCAN_RD;
                    end
                end
                S_SCAN_RD:
                begin
                    if ((2*ROOT_W)'(sq) >= (2*ROOT_W)'(PRIME_LIMIT))
                    begin
                        addr_reg  <= SCAN_W'(2);
                        state_reg <= S_LIST;
                    end
                    else
                    begin
                        state_reg <= S_SCAN_CHK;
                    end
                end
                S_SCAN_CHK:
                begin
                    if (!mem_rd)
                    begin
                        addr_reg  <= SCAN_W'(sq);
                        state_reg <= S_MARK;
                    end
                    else
                    begin
                        root_reg  <= root_reg + 1'b1;
                        state_reg <= S_SCAN_RD;
                    end
                end
                S_MARK:
                begin
                    addr_reg <= step_next;
                    if (step_next >= LIMIT_V)
                    begin
                        root_reg  <= root_reg + 1'b1;
                        state_reg <= S_SCAN_RD;
                    end
                end
                S_LIST:
                begin
                    lv_reg   <= 1'b1;
                    la_reg   <= addr_reg;
                    addr_reg <= addr_reg + 1'b1;
                    if (addr_reg == LAST_V)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                default:
                begin
                    state_reg <= S_DONE;
                end
            endcase
            step_reg <= la_reg;
        end
    end

    // primes go to the list in ascending order
    assign pwr.we   = lv_reg && !mem_rd && total_reg < TOTAL_W'(PRIME_SLOTS);
    assign pwr.addr = total_reg[SLOT_AW-1:0];
    assign pwr.data = la_reg[MARK_AW-1:0];
    assign done     = (state_reg == S_DONE) && !lv_reg && (step_reg == la_reg);
    assign total    = total_reg;

endmodule

[rtl/core/dct_divider.sv]
module dct_divider
    import dct_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   go,
    input  logic [NUMBER_BITS-1:0] dividend,
    input  logic [MARK_AW-1:0]     divisor,
    output logic                   done,
    output logic [NUMBER_BITS-1:0] quotient,
    output logic                   rem_zero
);

    logic [NUMBER_BITS-1:0] q_reg;
    logic [MARK_AW:0]       r_reg;
    logic [MARK_AW-1:0]     d_reg;
    logic [DIV_CW-1:0]      cnt_reg;
    logic                   busy_reg;
    logic                   done_reg;

    logic [MARK_AW+1:0]     trial;
    logic [MARK_AW+1:0]     diff;

    // one quotient bit per cycle, restoring
    assign trial = {r_reg, q_reg[NUMBER_BITS-1]};
    assign diff  = trial - (MARK_AW+2)'(d_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CW'(NUMBER_BITS - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[MARK_AW+1])
            begin
                r_reg <= diff[MARK_AW:0];
                q_reg <= {q_reg[NUMBER_BITS-2:0], 1'b1};
            end
            else
            begin
                r_reg <= trial[MARK_AW:0];
                q_reg <= {q_reg[NUMBER_BITS-2:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;
    assign rem_zero = (r_reg == '0);

endmodule

[rtl/core/dct_factor.sv]
`include "divisor_count_trial_division_defines.svh"

module dct_factor
    import dct_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   go,
    input  logic [NUMBER_BITS-1:0] number,
    input  logic [TOTAL_W-1:0]     total,
    output logic [SLOT_AW-1:0]     rd_addr,
    input  logic [MARK_AW-1:0]     rd_data,
    output logic                   active,
    output logic                   result_valid,
    output logic [COUNT_W-1:0]     result
);

    typedef enum logic [2:0] {
        F_IDLE, F_FETCH, F_WAIT, F_CHECK, F_DIV, F_FINISH
    } state_t;

    state_t                 state_reg;
    logic [NUMBER_BITS-1:0] n_reg;
    logic [MARK_AW-1:0]     p_reg;
    logic [TOTAL_W-1:0]     k_reg;
    logic [EXP_W-1:0]       e_reg;
    logic [COUNT_W-1:0]     count_reg;
    logic                   out_vld_reg;
    logic                   div_go;
    logic [NUMBER_BITS-1:0] div_n;
    logic [MARK_AW-1:0]     div_p;

    logic                   div_done;
    logic [NUMBER_BITS-1:0] div_q;
    logic                   div_rz;

    logic [2*MARK_AW-1:0]   psq;
    logic [COUNT_W+EXP_W:0] prod;
    logic [COUNT_W-1:0]     prod_sat;
    logic                   stop;

    dct_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (div_go),
        .dividend (div_n),
        .divisor  (div_p),
        .done     (div_done),
        .quotient (div_q),
        .rem_zero (div_rz)
    );

    // divider operands: fresh prime from the list, reduced value on a repeat
    assign div_n = (state_reg == F_DIV) ? div_q : n_reg;
    assign div_p = (state_reg == F_CHECK) ? rd_data : p_reg;

    // square of the current prime against the remaining value
    assign psq  = rd_data * rd_data;
    assign stop = (k_reg >= total) || (rd_data < MARK_AW'(2))
                  || ((NUMBER_BITS+2*MARK_AW)'(psq) > (NUMBER_BITS+2*MARK_AW)'(n_reg));

    // saturating count update by exponent plus one
    assign prod     = count_reg * ((EXP_W+1)'(e_reg) + 1'b1);
    assign prod_sat = (prod > (COUNT_W+EXP_W+1)'(COUNT_MAX)) ? COUNT_MAX : prod[COUNT_W-1:0];

    assign div_go  = (state_reg == F_CHECK && !stop)
                     || (state_reg == F_DIV && div_done && div_rz);
    assign rd_addr = k_reg[SLOT_AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= F_IDLE;
            k_reg       <= '0;
            e_reg       <= '0;
            count_reg   <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= 1'b0;
            case (state_reg)
                F_IDLE:
                begin
                    if (go)
                    begin
                        k_reg     <= '0;
                        count_reg <= COUNT_W'(1);
                        state_reg <= F_FETCH;
                    end
                end
                F_FETCH:
                begin
                    state_reg <= F_WAIT;
                end
                F_WAIT:
                begin
                    state_reg <= F_CHECK;
                end
                F_CHECK:
                begin
                    e_reg <= '0;
                    state_reg <= stop ? F_FINISH : F_DIV;
                end
                F_DIV:
                begin
                    if (div_done)
                    begin
                        if (div_rz)
                        begin
                            e_reg <= e_reg + 1'b1;
                        end
                        else
                        begin
                            if (e_reg != '0)
                            begin
                                count_reg <= prod_sat;
                            end
                            k_reg     <= k_reg + 1'b1;
                            state_reg <= F_FETCH;
                        end
                    end
                end
                F_FINISH:
                begin
                    if (n_reg > NUMBER_BITS'(1))
                    begin
                        count_reg <= (count_reg[COUNT_W-1]) ? COUNT_MAX
                                     : {count_reg[COUNT_W-2:0], 1'b0};
                    end
                    out_vld_reg <= 1'b1;
                    state_reg   <= F_IDLE;
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

    // remaining value and current prime
    always_ff @(posedge clk)
    begin
        if (state_reg == F_IDLE && go)
        begin
            n_reg <= number;
        end
        else if (state_reg == F_DIV && div_done && div_rz)
        begin
            n_reg <= div_q;
        end
        if (state_reg == F_CHECK)
        begin
            p_reg <= rd_data;
        end
    end

    assign active       = (state_reg != F_IDLE);
    assign result_valid = out_vld_reg;
    assign result       = count_reg;

    `DCT_ASSERT_NOW(a_div_nonzero, state_reg == F_DIV && div_done, p_reg >= MARK_AW'(2), "divide by a non-prime")
    `DCT_ASSERT_NOW(a_count_nonzero, out_vld_reg, count_reg != '0, "zero divisor count")
    `DCT_ASSERT_NEXT(a_result_once, out_vld_reg, !out_vld_reg, "result strobe longer than a cycle")
    `DCT_ASSERT_NOW(a_index_bound, state_reg == F_DIV, k_reg < total, "prime index beyond list")

endmodule

[rtl/core/divisor_count_trial_division.sv]
// divisor count by prime factorisation
// channels: an item (number) is taken at a rising edge where start is high
//   and busy is low. one result (divisor_count) per item is shown for a single
//   cycle with result_valid high; the receiver cannot stall and must take it.
// reset: rst_n clears control. the block then clears its 65536-entry mark
//   store, runs the sieve over it and walks the store once more to build
//   the prime list. busy stays high through all of this.
// sequence: each prime is fetched from the list and tested (F_FETCH, F_WAIT,
//   F_CHECK), then trial divided in the serial divider; every prime whose
//   square is at most the remaining value costs one failing division plus one
//   per factor found, then the block finishes in F_FINISH.
// items: one item at a time; a large prime input near 2^32 walks all
//   6542 primes through the bit-serial divider.
// inputs at or above 65536 squared cannot occur on a 32-bit port.
module divisor_count_trial_division
    import dct_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [NUMBER_BITS-1:0] number,
    output logic                   result_valid,
    output logic [COUNT_W-1:0]     divisor_count
);

    plist_wr_t          pwr;
    logic               sieve_done;
    logic [TOTAL_W-1:0] total;
    logic [SLOT_AW-1:0] rd_addr;
    logic [MARK_AW-1:0] rd_data;
    logic               active;
    logic               accept;

    assign accept = start && !busy;
    assign busy   = !sieve_done || active;

    // sieve builds the prime list after reset
    dct_sieve u_sieve (
        .clk   (clk),
        .rst_n (rst_n),
        .pwr   (pwr),
        .done  (sieve_done),
        .total (total)
    );

    // prime list store
    dct_plist u_plist (
        .clk     (clk),
        .wr      (pwr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // trial division sequencer
    dct_factor u_factor (
        .clk          (clk),
        .rst_n        (rst_n),
        .go           (accept),
        .number       (number),
        .total        (total),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .active       (active),
        .result_valid (result_valid),
        .result       (divisor_count)
    );

endmodule

[sim/divisor_count_trial_division_test.sv]
`timescale 1ns / 1ps

module divisor_count_trial_division_test;
    import dct_pkg::*;

    localparam longint CYCLE_LIMIT = 64'd100000000;
    localparam int     DRAIN_CYCLES = 64;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   start = 1'b0;
    logic [NUMBER_BITS-1:0] number = '0;
    logic                   busy;
    logic                   result_valid;
    logic [COUNT_W-1:0]     divisor_count;

    // primes below the limit, built once by the testbench's own sieve
    int unsigned      known_primes[$];
    logic [COUNT_W-1:0] expected_counts[$];
    int               errors = 0;
    longint           cycle_count = 0;
    int               idle_pct = 0;

    divisor_count_trial_division u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .number        (number),
        .result_valid  (result_valid),
        .divisor_count (divisor_count)
    );

    always #2 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("divisor_count_trial_division_test: FAIL");
            $finish;
        end
    end

    // compare each result with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (expected_counts.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result divisor_count=%0d", $time, divisor_count);
            end
            else
            begin
                if (divisor_count !== expected_counts[0])
                begin
                    errors++;
                    $display("%0t: divisor_count expected %0d actual %0d",
                             $time, expected_counts[0], divisor_count);
                end
                void'(expected_counts.pop_front());
            end
        end
    end

    task automatic sieve_primes();
        bit marks[PRIME_LIMIT];
        longint i, j;
        for (i = 2; i * i < PRIME_LIMIT; i++)
        begin
            if (!marks[i])
            begin
                for (j = i * i; j < PRIME_LIMIT; j += i)
                    marks[j] = 1'b1;
            end
        end
        for (i = 2; i < PRIME_LIMIT; i++)
        begin
            if (!marks[i] && known_primes.size() < PRIME_SLOTS)
                known_primes.insert(known_primes.size(), int'(i));
        end
    endtask

    // number of divisors by trial division, saturating
    function automatic logic [COUNT_W-1:0] count_divisors(logic [NUMBER_BITS-1:0] value);
        longint unsigned rest, p, total, e;
        rest = value;
        total = 1;
        foreach (known_primes[k])
        begin
            p = known_primes[k];
            if (p * p > rest)
                break;
            e = 0;
            while (rest % p == 0)
            begin
                rest = rest / p;
                e++;
            end
            if (e != 0)
                total = total * (e + 1);
            if (total > COUNT_MAX)
                total = COUNT_MAX;
        end
        if (rest > 1)
            total = total * 2;
        if (total > COUNT_MAX)
            total = COUNT_MAX;
        return total[COUNT_W-1:0];
    endfunction

    // offer one item, with a random pause first when idling is on
    task automatic send_number(logic [NUMBER_BITS-1:0] value);
        if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(8, 1)) @(posedge clk);
        end
        start  <= 1'b1;
        number <= value;
        do
            @(posedge clk);
        while (busy);
        expected_counts.insert(expected_counts.size(), count_divisors(value));
    endtask

    task automatic wait_results_done();
        start <= 1'b0;
        while (expected_counts.size() != 0)
            @(posedge clk);
    endtask

    // extremes, tiny values and the highly composite case
    task automatic test_edge_values();
        send_number(32'd0);
        send_number(32'd1);
        send_number(32'd2);
        send_number(32'd3);
        send_number(32'd4);
        send_number(32'hFFFF_FFFF);
        send_number(32'h8000_0000);
        send_number(32'd735134400);
        send_number(32'd65536);
        send_number(32'd65521);
        send_number(32'd65537);
        send_number(32'd4293001441 / 65521);
        send_number(32'hAAAA_AAAA);
        send_number(32'h5555_5555);
    endtask

    // largest prime below 2^32 walks the whole list
    task automatic test_worst_case_prime();
        send_number(32'd4294967291);
    endtask

    task automatic test_small_numbers(int items);
        repeat (items)
            send_number($urandom_range(65535, 0));
    endtask

    // products of listed primes, sometimes with a big prime cofactor
    task automatic test_smooth_numbers(int items);
        longint unsigned prod, p;
        repeat (items)
        begin
            prod = 1;
            repeat ($urandom_range(12, 1))
            begin
                if ($urandom_range(9, 0) == 0)
                    p = known_primes[$urandom_range(known_primes.size() - 1, 0)];
                else
                    p = known_primes[$urandom_range(25, 0)];
                if (prod * p < 64'h1_0000_0000)
                    prod = prod * p;
            end
            send_number(prod[NUMBER_BITS-1:0]);
        end
    endtask

    task automatic test_medium_numbers(int items);
        repeat (items)
            send_number($urandom_range(32'h00FF_FFFF, 0));
    endtask

    task automatic test_full_range(int items);
        repeat (items)
            send_number($urandom());
    endtask

    initial
    begin
        sieve_primes();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        idle_pct = 0;
        test_edge_values();
        test_worst_case_prime();
        test_small_numbers(20);

        idle_pct = 47;
        test_smooth_numbers(20);
        // hold off until every result is back
        wait_results_done();
        test_small_numbers(10);

        idle_pct = 30;
        test_medium_numbers(15);
        test_smooth_numbers(15);

        idle_pct = 0;
        test_full_range(4);
        test_small_numbers(10);

        wait_results_done();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("divisor_count_trial_division_test: PASS");
        else
            $display("divisor_count_trial_division_test: FAIL");
        $finish;
    end

endmodule
